// ===== src/slim_pkg.sv =====
// Package: payload types, action and status codes for the sorted list core.
package slim_pkg;

  localparam int VALUE_W = 32;

  localparam logic [1:0] ACT_INSERT_FIRST  = 2'd0;
  localparam logic [1:0] ACT_INSERT_SECOND = 2'd1;
  localparam logic [1:0] ACT_MERGE         = 2'd2;
  // Spare code: the core ignores it, no result and no state change.
  localparam logic [1:0] ACT_UNUSED        = 2'd3;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MERGED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic [1:0]                status;
    logic                      last;
  } out_item_t;

endpackage

// ===== src/sorted_list_insert_and_merge_core.sv =====
// Top level: two sorted stores in block memories with sorted insert and merged read-out.
//
//   channel | ports                      | beat taken when
//   --------+----------------------------+-------------------------------
//   input   | start, busy, in_data       | start high and busy low
//   result  | out_valid, out_data        | every cycle out_valid is high
//
// Steps: an insert into a store walks down from the tail, one read-compare-shift
// step per entry moved through the store's single read port, until the value
// lands; a full store or an empty store answers directly, with no walk.
// A merge streams one element per cycle, limited by one read per store memory
// per cycle; an empty merge answers with a single status beat.
// Reset clears the state, the fill counts and out_valid; the memories need no clearing pass.
// The result side cannot stall: each result beat is shown for one cycle.
module sorted_list_insert_and_merge_core #(
  parameter int STORE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  slim_pkg::in_item_t  in_data,
  output logic                out_valid,
  output slim_pkg::out_item_t out_data
);
  import slim_pkg::*;

  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_MERGE = 2'd3;

  // Store memories: one write and one registered read per cycle each.
  logic signed [VALUE_W-1:0] mem_a [STORE_DEPTH];
  logic signed [VALUE_W-1:0] mem_b [STORE_DEPTH];
  logic signed [VALUE_W-1:0] rdata_a_r;
  logic signed [VALUE_W-1:0] rdata_b_r;

  logic [1:0]   state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          sel_r, sel_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  // Memory access controls for this cycle.
  logic          we_a, we_b;
  logic [IW-1:0] waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic [CW-1:0] rd_ptr_a, rd_ptr_b;
  logic [IW-1:0] rd_addr_a, rd_addr_b;

  // Working values.
  logic signed [VALUE_W-1:0] rdata_sel;
  logic          a_ok, b_ok, take_a;
  logic [CW-1:0] ia_adv, ib_adv;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rdata_sel = sel_r ? rdata_b_r : rdata_a_r;

  // Merge head selection: first store wins ties.
  assign a_ok   = (ia_r < cnt_a_r);
  assign b_ok   = (ib_r < cnt_b_r);
  assign take_a = a_ok && (!b_ok || (rdata_a_r <= rdata_b_r));
  assign ia_adv = ia_r + CW'(take_a);
  assign ib_adv = ib_r + CW'(!take_a);

  // Keep read addresses in range; pointers past the end are never used.
  assign rd_addr_a = (rd_ptr_a < CW'(STORE_DEPTH)) ? rd_ptr_a[IW-1:0] : '0;
  assign rd_addr_b = (rd_ptr_b < CW'(STORE_DEPTH)) ? rd_ptr_b[IW-1:0] : '0;

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    idx_nxt       = idx_r;
    sel_nxt       = sel_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    we_a          = 1'b0;
    we_b          = 1'b0;
    waddr         = idx_r;
    wdata         = val_r;
    rd_ptr_a      = '0;
    rd_ptr_b      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_data.action) inside
            ACT_INSERT_FIRST, ACT_INSERT_SECOND: begin
              sel_nxt = (in_data.action == ACT_INSERT_SECOND);
              val_nxt = in_data.value;
              out_data_nxt.value_res = '0;
              out_data_nxt.last      = 1'b1;
              if (sel_nxt ? (cnt_b_r >= CW'(STORE_DEPTH))
                          : (cnt_a_r >= CW'(STORE_DEPTH))) begin
                // Drop the value, store untouched.
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_FULL;
              end else if ((sel_nxt ? cnt_b_r : cnt_a_r) == '0) begin
                // Empty store: place at the head at once.
                we_a  = !sel_nxt;
                we_b  = sel_nxt;
                waddr = '0;
                wdata = in_data.value;
                if (sel_nxt) cnt_b_nxt = cnt_b_r + 1'b1;
                else         cnt_a_nxt = cnt_a_r + 1'b1;
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_INSERTED;
              end else begin
                // Start the shift from the tail: fetch the last entry.
                if (sel_nxt) begin
                  rd_ptr_b = cnt_b_r - 1'b1;
                  idx_nxt  = cnt_b_r[IW-1:0];
                end else begin
                  rd_ptr_a = cnt_a_r - 1'b1;
                  idx_nxt  = cnt_a_r[IW-1:0];
                end
                state_nxt = S_SHIFT;
              end
            end
            ACT_MERGE: begin
              if ((cnt_a_r == '0) && (cnt_b_r == '0)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.value_res = '0;
                out_data_nxt.status    = ST_EMPTY;
                out_data_nxt.last      = 1'b1;
              end else begin
                ia_nxt    = '0;
                ib_nxt    = '0;
                state_nxt = S_MERGE;
              end
            end
            default: begin
              // Unused action: drop the beat, no result.
            end
          endcase
        end
      end

      S_SHIFT: begin
        we_a  = !sel_r;
        we_b  = sel_r;
        waddr = idx_r;
        if (rdata_sel > val_r) begin
          // Move the larger entry up one slot and step down.
          wdata = rdata_sel;
          if (idx_r == IW'(1)) begin
            idx_nxt   = '0;
            state_nxt = S_PLACE;
          end else begin
            idx_nxt = idx_r - 1'b1;
            if (sel_r) rd_ptr_b = CW'(idx_r - IW'(2));
            else       rd_ptr_a = CW'(idx_r - IW'(2));
          end
        end else begin
          // Entry below is not larger: the value lands here.
          wdata = val_r;
          if (sel_r) cnt_b_nxt = cnt_b_r + 1'b1;
          else       cnt_a_nxt = cnt_a_r + 1'b1;
          out_valid_nxt          = 1'b1;
          out_data_nxt.value_res = '0;
          out_data_nxt.status    = ST_INSERTED;
          out_data_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      S_PLACE: begin
        we_a  = !sel_r;
        we_b  = sel_r;
        waddr = '0;
        wdata = val_r;
        if (sel_r) cnt_b_nxt = cnt_b_r + 1'b1;
        else       cnt_a_nxt = cnt_a_r + 1'b1;
        out_valid_nxt          = 1'b1;
        out_data_nxt.value_res = '0;
        out_data_nxt.status    = ST_INSERTED;
        out_data_nxt.last      = 1'b1;
        state_nxt              = S_IDLE;
      end

      S_MERGE: begin
        // Emit the smaller head, advance its pointer, fetch the next head.
        ia_nxt   = ia_adv;
        ib_nxt   = ib_adv;
        rd_ptr_a = ia_adv;
        rd_ptr_b = ib_adv;
        out_valid_nxt          = 1'b1;
        out_data_nxt.value_res = take_a ? rdata_a_r : rdata_b_r;
        out_data_nxt.status    = ST_MERGED;
        out_data_nxt.last      = (ia_adv == cnt_a_r) && (ib_adv == cnt_b_r);
        if (out_data_nxt.last) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_a) mem_a[waddr] <= wdata;
    rdata_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[waddr] <= wdata;
    rdata_b_r <= mem_b[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers: no reset needed.
  always_ff @(posedge clk) begin
    ia_r       <= ia_nxt;
    ib_r       <= ib_nxt;
    idx_r      <= idx_nxt;
    sel_r      <= sel_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== src/slim_checker.sv =====
// Checker: port-level assertions for the sorted list core, with its bind.
module slim_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input slim_pkg::in_item_t  in_data,
  input logic                out_valid,
  input slim_pkg::out_item_t out_data
);
  import slim_pkg::*;

  // Insert and empty-merge answers are single status beats.
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_INSERTED || out_data.status == ST_FULL ||
                  out_data.status == ST_EMPTY)
    |-> out_data.last && (out_data.value_res == '0))
    else $error("status beat not single or value not zero");

  // A merge stream runs without gaps until its last element.
  a_merge_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_MERGED) && !out_data.last
    |=> out_valid && (out_data.status == ST_MERGED))
    else $error("gap in merge stream");

  // Mid-stream the block still holds off new input.
  a_busy_mid_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("block idle while stream unfinished");

  // An unused action leaves no trace.
  a_unused_action: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.action == ACT_UNUSED) |=> !out_valid && !busy)
    else $error("unused action produced activity");

endmodule

bind sorted_list_insert_and_merge_core slim_checker u_slim_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== dv/sorted_list_insert_and_merge_core_tb.sv =====
// Testbench: random and directed insert/merge traffic checked against a queue-based sorted model.
module sorted_list_insert_and_merge_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slim_pkg::*;

  localparam int STORE_DEPTH = 32;
  localparam int RANDOM_BEATS = 200;
  localparam int MAX_SHOWN = 20;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef value_t value_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;

  sorted_list_insert_and_merge_core #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Beats waiting to be offered, the model's copy of both stores, and the results still due.
  in_item_t  beat_queue[$];
  value_q_t  first_sorted;
  value_q_t  second_sorted;
  out_item_t awaited_results[$];

  int beats_planned = 0;
  int beats_taken = 0;
  int error_count = 0;
  int insert_beats = 0;
  int dropped_beats = 0;
  int merge_beats = 0;
  int merged_elems = 0;

  // Update the model for one accepted beat and queue the results it must cause.
  task automatic predict_outcome(in_item_t beat);
    value_q_t   chosen;
    int         slot;
    int         ia;
    int         ib;
    int         total;
    logic [1:0] status;
    bit         take_first;
    value_t     pick;
    case (beat.action) inside
      ACT_INSERT_FIRST, ACT_INSERT_SECOND: begin
        chosen = (beat.action == ACT_INSERT_FIRST) ? first_sorted : second_sorted;
        insert_beats++;
        if (chosen.size() >= STORE_DEPTH) begin
          // Full store: drop the value, leave the store alone.
          status = ST_FULL;
          dropped_beats++;
        end else begin
          // Land after every entry that is less than or equal to the new value.
          slot = 0;
          while (slot < chosen.size() && chosen[slot] <= beat.value) slot++;
          chosen.insert(slot, beat.value);
          status = ST_INSERTED;
        end
        if (beat.action == ACT_INSERT_FIRST) first_sorted = chosen;
        else second_sorted = chosen;
        awaited_results.push_back('{value_res: '0, status: status, last: 1'b1});
      end
      ACT_MERGE: begin
        merge_beats++;
        total = first_sorted.size() + second_sorted.size();
        if (total == 0) begin
          awaited_results.push_back('{value_res: '0, status: ST_EMPTY, last: 1'b1});
        end else begin
          ia = 0;
          ib = 0;
          for (int k = 0; k < total; k++) begin
            // Ties go to the first store; an exhausted store yields to the other.
            if (ia >= first_sorted.size()) take_first = 1'b0;
            else if (ib >= second_sorted.size()) take_first = 1'b1;
            else take_first = (first_sorted[ia] <= second_sorted[ib]);
            if (take_first) begin
              pick = first_sorted[ia];
              ia++;
            end else begin
              pick = second_sorted[ib];
              ib++;
            end
            awaited_results.push_back('{value_res: pick, status: ST_MERGED,
                                        last: (k == total - 1)});
          end
          merged_elems += total;
        end
      end
      default: begin
        // Unused action: nothing comes back.
      end
    endcase
  endtask

  task automatic flag_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    error_count++;
    if (error_count <= MAX_SHOWN)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
  endtask

  // Driver: offer queued beats in bursts with random gaps; hold a beat while busy.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (beat_queue.size() != 0) begin
        in_data <= beat_queue.pop_front();
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // Mix long back-to-back stretches with short bursts; gaps may land mid-merge.
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: take input beats into the model, then check any result beat of this cycle.
  out_item_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_outcome(in_data);
        beats_taken++;
      end
      if (out_valid === 1'b1) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.value_res !== want.value_res)
            flag_field("value_res", want.value_res, out_data.value_res);
          if (out_data.status !== want.status)
            flag_field("status", 32'(want.status), 32'(out_data.status));
          if (out_data.last !== want.last)
            flag_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
    end
  end

  task automatic add_beat(logic [1:0] action, value_t value);
    beat_queue.push_back('{action: action, value: value});
    beats_planned++;
  endtask

  // Values: many small ones for ties, some at the signed extremes, the rest anywhere.
  function automatic value_t pick_value();
    value_t v;
    case ($urandom_range(0, 9)) inside
      0, 1, 2, 3: begin
        v = $urandom_range(0, 16);
        v = v - 8;
      end
      4, 5: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0001;
          default: v = 32'h7FFF_FFFE;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin : run_flow
    int counted;
    int roll;
    // Directed: empty merge, ignored action, one store alone, extremes, ties across stores.
    add_beat(ACT_MERGE, 32'h1234_5678);
    add_beat(ACT_UNUSED, 32'h0000_0000);
    add_beat(ACT_INSERT_SECOND, 32'h7FFF_FFFF);
    add_beat(ACT_INSERT_SECOND, 32'h8000_0000);
    add_beat(ACT_INSERT_SECOND, 32'h0000_0000);
    add_beat(ACT_INSERT_SECOND, 32'hFFFF_FFFF);
    add_beat(ACT_MERGE, 32'hFFFF_FFFF);
    add_beat(ACT_INSERT_FIRST, 32'h0000_0000);
    add_beat(ACT_INSERT_FIRST, 32'h8000_0000);
    add_beat(ACT_INSERT_FIRST, 32'h7FFF_FFFF);
    add_beat(ACT_INSERT_FIRST, 32'h0000_0005);
    add_beat(ACT_INSERT_FIRST, 32'h0000_0000);
    add_beat(ACT_INSERT_SECOND, 32'h0000_0005);
    add_beat(ACT_MERGE, 32'h0000_0000);
    add_beat(ACT_UNUSED, 32'hFFFF_FFFF);

    // Random: mostly inserts so both stores fill up and then overflow, merges in between.
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      roll = $urandom_range(0, 99);
      if (roll < 43) add_beat(ACT_INSERT_FIRST, pick_value());
      else if (roll < 86) add_beat(ACT_INSERT_SECOND, pick_value());
      else if (roll < 97) add_beat(ACT_MERGE, $urandom);
      else add_beat(ACT_UNUSED, $urandom);
      if (roll < 97) counted++;
    end
    // Close on a merge of whatever the stores hold by now.
    add_beat(ACT_MERGE, $urandom);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every beat taken and every result seen, then a tail for stray beats.
    while (beats_taken < beats_planned || awaited_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d inserts (%0d dropped on a full store), %0d merges, %0d merged elements",
             insert_beats, dropped_beats, merge_beats, merged_elems);
    $display("final store fill: first %0d, second %0d, errors %0d",
             first_sorted.size(), second_sorted.size(), error_count);
    if (error_count == 0) begin
      $display("sorted_list_insert_and_merge_core_tb passed");
    end else begin
      $display("sorted_list_insert_and_merge_core_tb failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("sorted_list_insert_and_merge_core_tb failed");
    $finish;
  end

endmodule
